### rtl/core/cache_line_request_splitter_defines.svh
// Assertion macros shared by the splitter RTL.
`ifndef CACHE_LINE_REQUEST_SPLITTER_DEFINES_SVH
`define CACHE_LINE_REQUEST_SPLITTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLRS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/clrs_pkg.sv
package clrs_pkg;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned SIZE_W   = 9;
    localparam int unsigned OFF_W    = 8;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned LOG2_W   = 4;
    localparam int unsigned LINE_W   = 9;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 64;

    // Fragment limit per access and the width of its counter.
    localparam int unsigned MAX_FRAGS = 33;
    localparam int unsigned CNT_W     = $clog2(MAX_FRAGS);

    // Depth of the job queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Line size limits and reset values.
    localparam logic [LOG2_W-1:0] LINE_LOG2_MIN   = 4'd3;
    localparam logic [LOG2_W-1:0] LINE_LOG2_MAX   = 4'd8;
    localparam logic [LOG2_W-1:0] LINE_LOG2_RESET = 4'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS    = 1'd1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  request_id;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] frag_address;
        logic [SIZE_W-1:0] frag_size;
        logic [OFF_W-1:0]  data_offset;
        logic              is_write;
        logic [TAG_W-1:0]  tag_out;
        logic              out_of_range;
        logic              last;
    } t_frag;

    // Classified access handed from front to back. A size of zero marks a
    // single-result job (empty access or read error).
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic              is_write;
        logic [TAG_W-1:0]  tag;
        logic              out_of_range;
    } t_job;

endpackage

### rtl/core/cache_line_request_splitter.sv
// Cache-line request splitter.
// Request channel (i_req_valid / o_req_ready, payload i_req) takes one access
// word: read or write, start address, byte size and request id. Fragment
// channel (o_frag_valid / i_frag_ready, payload o_frag) gives the access back
// as fragments that never cross a cache line, in address order, the final
// one marked last. A read running past max_address, or wrapping the address
// space, gives a single out-of-range word instead; an empty access gives one
// word of size zero. Configuration is written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user must write it only while the block is idle, which
// the block itself does not enforce. A request passes the job queue and then
// the output register before its first fragment can be taken. The fragment
// walker emits one fragment per cycle while the receiver takes them, and
// each access gives at least one. A two-entry job queue lets requests be
// taken while fragments wait. Reset clears the queue and the output register
// and restores a 64-byte line and an all-ones max_address. When the receiver
// stalls, the output word holds, the walker stops, and requests are taken
// until the queue is full.
module cache_line_request_splitter #(
    parameter int unsigned MAX_ACCESS_BYTES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  clrs_pkg::t_req                  i_req,
    output logic                            o_frag_valid,
    input  logic                            i_frag_ready,
    output clrs_pkg::t_frag                 o_frag,
    input  logic                            i_cfg_we,
    input  logic [clrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clrs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clrs_pkg::*;

    `include "cache_line_request_splitter_defines.svh"

    logic [LOG2_W-1:0] r_line_log2;
    logic [ADDR_W-1:0] r_max_address;
    logic [LOG2_W-1:0] line_log2;
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0]  line_mask;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    logic err_word_ok;
    logic frag_in_line;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_log2   <= LINE_LOG2_RESET;
            r_max_address <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_SIZE_LOG2: r_line_log2   <= i_cfg_data[LOG2_W-1:0];
                CFG_MAX_ADDRESS:    r_max_address <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Line size, clamped to the supported range.
    always_comb begin
        if (r_line_log2 < LINE_LOG2_MIN) begin
            line_log2 = LINE_LOG2_MIN;
        end else if (r_line_log2 > LINE_LOG2_MAX) begin
            line_log2 = LINE_LOG2_MAX;
        end else begin
            line_log2 = r_line_log2;
        end
    end

    assign line      = LINE_W'(1) << line_log2;
    assign line_mask = OFF_W'(line - LINE_W'(1));

    // Front end: accept and classify.
    clrs_front #(
        .MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
    ) u_front (
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_max_address(r_max_address),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (push_job)
    );

    // Job queue between the two halves.
    clrs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_job  (head_job)
    );

    // Back end: walk the fragments.
    clrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .i_line      (line),
        .i_line_mask (line_mask),
        .o_frag_valid(o_frag_valid),
        .i_frag_ready(i_frag_ready),
        .o_frag      (o_frag)
    );

    // Shape of an error word, and the end of a fragment against its line.
    assign err_word_ok  = o_frag.last && (o_frag.frag_size == '0) && !o_frag.is_write;
    assign frag_in_line = ({1'b0, {1'b0, o_frag.frag_address[OFF_W-1:0] & line_mask}}
                           + {1'b0, o_frag.frag_size}) <= {1'b0, line};

    // A queued job is visible to the back end in the following cycle.
    `CLRS_ASSERT_NEXT(a_push_visible, q_push && !q_pop, q_valid, "pushed job not visible")

    // An error word is a lone, empty read word.
    `CLRS_ASSERT_IMPLY(a_error_word, o_frag_valid && o_frag.out_of_range, err_word_ok, "bad error word")

    // No fragment runs past the end of its line.
    `CLRS_ASSERT_IMPLY(a_in_line, o_frag_valid, frag_in_line, "fragment crosses a line boundary")

endmodule

### rtl/core/clrs_front.sv
module clrs_front #(
    parameter int unsigned MAX_ACCESS_BYTES = 256
) (
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  clrs_pkg::t_req              i_req,
    input  logic [clrs_pkg::ADDR_W-1:0] i_max_address,
    input  logic                        i_q_full,
    output logic                        o_push,
    output clrs_pkg::t_job              o_job
);
    import clrs_pkg::*;

    // The size field cannot exceed its own width, so the cap is clipped too.
    localparam int unsigned SizeFieldMax = (1 << SIZE_W) - 1;
    localparam int unsigned SizeCap =
        (MAX_ACCESS_BYTES > SizeFieldMax) ? SizeFieldMax : MAX_ACCESS_BYTES;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SizeCap);

    logic [SIZE_W-1:0] size_sat;
    logic [ADDR_W:0]   last_byte;
    logic              is_empty;
    logic              rd_error;

    // A word is taken whenever the queue has room.
    assign o_req_ready = !i_q_full;
    assign o_push      = i_req_valid && o_req_ready;

    // Saturate the size to the largest access allowed.
    assign size_sat = (i_req.size > SIZE_CAP) ? SIZE_CAP : i_req.size;
    assign is_empty = (i_req.size == '0);

    // Last byte of a read; reaching the top address counts as overflow.
    assign last_byte = {1'b0, i_req.address} + (ADDR_W + 1)'(size_sat - SIZE_W'(1));
    assign rd_error  = !i_req.req_type && !is_empty &&
                       (last_byte[ADDR_W] || (&last_byte[ADDR_W-1:0]) ||
                        (last_byte[ADDR_W-1:0] > i_max_address));

    // Build the job for the back end.
    always_comb begin
        o_job.address      = i_req.address;
        o_job.tag          = i_req.request_id;
        o_job.out_of_range = rd_error;
        o_job.is_write     = rd_error ? 1'b0 : i_req.req_type;
        o_job.size         = (rd_error || is_empty) ? '0 : size_sat;
    end

endmodule

### rtl/core/clrs_queue.sv
module clrs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clrs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output clrs_pkg::t_job o_job
);
    import clrs_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### rtl/core/clrs_back.sv
module clrs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  clrs_pkg::t_job              i_job,
    output logic                        o_pop,
    input  logic [clrs_pkg::LINE_W-1:0] i_line,
    input  logic [clrs_pkg::OFF_W-1:0]  i_line_mask,
    output logic                        o_frag_valid,
    input  logic                        i_frag_ready,
    output clrs_pkg::t_frag             o_frag
);
    import clrs_pkg::*;

    logic              r_busy;
    logic [ADDR_W-1:0] r_cur;
    logic [SIZE_W-1:0] r_rem;
    logic [OFF_W-1:0]  r_off;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_wr;
    logic [TAG_W-1:0]  r_tag;
    logic              r_out_valid;
    t_frag             r_out;

    logic              out_free;
    logic              take;
    logic              single;
    logic [ADDR_W-1:0] s_cur;
    logic [SIZE_W-1:0] s_rem;
    logic [OFF_W-1:0]  s_off;
    logic [CNT_W-1:0]  s_cnt;
    logic              s_wr;
    logic [TAG_W-1:0]  s_tag;
    logic [LINE_W-1:0] room;
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] rem_next;
    logic              fin;
    t_frag             frag;

    assign out_free = !r_out_valid || i_frag_ready;
    assign take     = out_free && (r_busy || i_q_valid);
    assign o_pop    = take && !r_busy;

    // Work from the running access, or start the next job from the queue.
    assign s_cur = r_busy ? r_cur : i_job.address;
    assign s_rem = r_busy ? r_rem : i_job.size;
    assign s_off = r_busy ? r_off : '0;
    assign s_cnt = r_busy ? r_cnt : '0;
    assign s_wr  = r_busy ? r_wr  : i_job.is_write;
    assign s_tag = r_busy ? r_tag : i_job.tag;
    assign single = !r_busy && (i_job.size == '0);

    // Bytes left in the current line bound the fragment.
    assign room     = i_line - {1'b0, s_cur[OFF_W-1:0] & i_line_mask};
    assign n        = single ? '0 : ((s_rem < room) ? s_rem : room);
    assign rem_next = s_rem - n;
    assign fin      = single || (rem_next == '0) || (s_cnt == CNT_W'(MAX_FRAGS - 1));

    always_comb begin
        frag.frag_address = s_cur;
        frag.frag_size    = n;
        frag.data_offset  = s_off;
        frag.is_write     = s_wr;
        frag.tag_out      = s_tag;
        frag.out_of_range = single && i_job.out_of_range;
        frag.last         = fin;
    end

    // Fragment walker control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_busy      <= !fin;
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    // Running position and the output word.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur <= s_cur + ADDR_W'(n);
            r_rem <= rem_next;
            r_off <= s_off + n[OFF_W-1:0];
            r_cnt <= s_cnt + 1'b1;
            r_wr  <= s_wr;
            r_tag <= s_tag;
            r_out <= frag;
        end
    end

    assign o_frag_valid = r_out_valid;
    assign o_frag       = r_out;

endmodule
